// ----- hdl/snooping_bus_request_sequencer_unit_macros.svh -----
// Assertion macros for the snooping bus request sequencer.
// Used by sbrs_request_queue and snooping_bus_request_sequencer_unit; needs ports clock and reset.
`ifndef SNOOPING_BUS_REQUEST_SEQUENCER_UNIT_MACROS_SVH
`define SNOOPING_BUS_REQUEST_SEQUENCER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SBRS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SBRS_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define SBRS_ASSERT(lbl, prop, msg)
`define SBRS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hdl/sbrs_pkg.sv -----
// Shared types, codes and defaults of the snooping bus request sequencer.
// No dependencies.
package sbrs_pkg;

   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_CACHE_COUNT  = 8;
   localparam int DEF_ADDRESS_BITS = 32;

   localparam int REQ_ID_W   = 3;
   localparam int REQ_TYPE_W = 3;
   localparam int LAT_W      = 10;
   localparam int BLK_W      = 11;
   localparam int CNT_W      = 64;

   // item actions
   localparam logic [1:0] ACT_PUSH      = 2'd0;
   localparam logic [1:0] ACT_TICK      = 2'd1;
   localparam logic [1:0] ACT_WRITEBACK = 2'd2;

   // bus request types
   localparam logic [REQ_TYPE_W-1:0] RT_BUS_RD    = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] RT_BUS_RDX   = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] RT_WRITEBACK = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] RT_FLUSH     = 3'd3;

   // line states in completion notices
   localparam logic [1:0] LS_SHARED    = 2'd0;
   localparam logic [1:0] LS_EXCLUSIVE = 2'd1;
   localparam logic [1:0] LS_MODIFIED  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_BUS_LATENCY    = 2'd0;
   localparam logic [1:0] CSR_MEMORY_LATENCY = 2'd1;
   localparam logic [1:0] CSR_BLOCK_SIZE     = 2'd2;

   localparam logic [LAT_W-1:0] RST_BUS_LATENCY    = 10'd2;
   localparam logic [LAT_W-1:0] RST_MEMORY_LATENCY = 10'd100;
   localparam logic [BLK_W-1:0] RST_BLOCK_SIZE     = 11'd32;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hdl/sbrs_request_queue.sv -----
// Request FIFO of the sequencer: register-array storage with a registered head read.
// Depends on sbrs_pkg and snooping_bus_request_sequencer_unit_macros.svh.
`include "snooping_bus_request_sequencer_unit_macros.svh"

module sbrs_request_queue
   import sbrs_pkg::*;
#(
   parameter int  QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int  ENTRY_W     = REQ_ID_W + REQ_TYPE_W + DEF_ADDRESS_BITS,
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  queue_ctrl_type       ctrl,
   input  logic [ENTRY_W-1:0]   wr_data,
   output queue_status_type     status,
   output logic [FILL_W-1:0]    fill,
   output logic [ENTRY_W-1:0]   head_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [ENTRY_W-1:0] head_data_ff;
   logic               write_en, read_en;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign status.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign write_en     = ctrl.push & ~status.full;
   assign read_en      = ctrl.pop & ~status.empty;

   always_comb begin
      head_in = read_en  ? next_ptr(head_ff) : head_ff;
      tail_in = write_en ? next_ptr(tail_ff) : tail_ff;
      case ({write_en, read_en})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // storage; head word is prefetched for the next cycle, bypassing a same-slot write
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[tail_ff] <= wr_data;
      end
      if (write_en && (tail_ff == head_in)) begin
         head_data_ff <= wr_data;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign fill      = fill_ff;
   assign head_data = head_data_ff;

   `SBRS_ASSERT_NEVER(a_fill_bound, fill_ff > FILL_W'(QUEUE_DEPTH), "queue fill above depth")
   `SBRS_ASSERT(a_pop_drains, (read_en && !write_en) |=> (fill_ff == $past(fill_ff) - 1'b1), "pop did not drain")
   `SBRS_ASSERT(a_head_bypass, (write_en && status.empty) |=> (head_data_ff == $past(wr_data)), "head bypass lost")

endmodule

// ----- hdl/snooping_bus_request_sequencer_unit.sv -----
// Top level of the snooping bus request sequencer: command decode, bus timing, counters.
// Depends on sbrs_pkg, sbrs_request_queue and snooping_bus_request_sequencer_unit_macros.svh.
//
// Usage:
//  - Command channel: an item transfers on a rising edge with start high and busy low.
//    busy is high only during reset, so one item may be sent every cycle.
//    req_action selects push (queue a bus request), tick (one bus cycle) or writeback notice.
//  - Result channel: every item yields exactly one result, shown on the rsp_ ports for one
//    cycle with rsp_valid high, in the cycle after the command transfer (throughput 1 item
//    per cycle). The receiver cannot stall; results are not held.
//  - Per-item work is one pass of logic between the command ports and the result and
//    state registers; the queue head is prefetched into a register.
//  - rsp_queue_count, rsp_traffic_bytes and rsp_transaction_count show the state after
//    the item; the strobe fields are zero when not set.
//  - Configuration: csr_write_enable with csr_index and csr_write_data; write while idle.
//  - Reset (synchronous): queue empty, bus idle, counters zero, latencies 2 and 100,
//    block size 32. Queue storage is not cleared; only written entries are read.
`include "snooping_bus_request_sequencer_unit_macros.svh"

module snooping_bus_request_sequencer_unit
   import sbrs_pkg::*;
#(
   parameter int  QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int  CACHE_COUNT  = DEF_CACHE_COUNT,
   parameter int  ADDRESS_BITS = DEF_ADDRESS_BITS,
   localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_action,
   input  logic [REQ_ID_W-1:0]     req_requester_id,
   input  logic [REQ_TYPE_W-1:0]   req_request_type,
   input  logic [ADDRESS_BITS-1:0] req_address,
   input  logic                    req_snoop_supplied,
   // result channel
   output logic                    rsp_valid,
   output logic                    rsp_notify_valid,
   output logic [REQ_ID_W-1:0]     rsp_notify_requester,
   output logic [ADDRESS_BITS-1:0] rsp_notify_address,
   output logic [1:0]              rsp_notify_state,
   output logic                    rsp_start_valid,
   output logic [REQ_ID_W-1:0]     rsp_start_requester,
   output logic [REQ_TYPE_W-1:0]   rsp_start_type,
   output logic [ADDRESS_BITS-1:0] rsp_start_address,
   output logic [FILL_W-1:0]       rsp_queue_count,
   output logic [CNT_W-1:0]        rsp_traffic_bytes,
   output logic [CNT_W-1:0]        rsp_transaction_count,
   output logic                    rsp_push_dropped,
   // configuration port
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_index,
   input  logic [BLK_W-1:0]        csr_write_data
);

   localparam int ENTRY_W = REQ_ID_W + REQ_TYPE_W + ADDRESS_BITS;

   // configuration registers
   logic [LAT_W-1:0] bus_latency_ff;
   logic [LAT_W-1:0] memory_latency_ff;
   logic [BLK_W-1:0] block_size_ff;

   // bus state
   logic               bus_busy_ff, bus_busy_in;
   logic [LAT_W-1:0]   cycles_ff, cycles_in;
   logic [ENTRY_W-1:0] active_ff, active_in;
   logic               served_ff, served_in;
   logic [CNT_W-1:0]   traffic_ff, traffic_in;
   logic [CNT_W-1:0]   trans_ff, trans_in;

   // result registers
   logic                    rsp_valid_ff;
   logic                    notify_valid_ff, notify_valid_in;
   logic [REQ_ID_W-1:0]     notify_req_ff, notify_req_in;
   logic [ADDRESS_BITS-1:0] notify_addr_ff, notify_addr_in;
   logic [1:0]              notify_state_ff, notify_state_in;
   logic                    start_valid_ff, start_valid_in;
   logic [REQ_ID_W-1:0]     start_req_ff, start_req_in;
   logic [REQ_TYPE_W-1:0]   start_type_ff, start_type_in;
   logic [ADDRESS_BITS-1:0] start_addr_ff, start_addr_in;
   logic                    dropped_ff, dropped_in;

   // queue interface
   queue_ctrl_type     q_ctrl;
   queue_status_type   q_status;
   logic [FILL_W-1:0]  q_fill;
   logic [ENTRY_W-1:0] q_head;
   logic [ENTRY_W-1:0] q_wr_data;

   logic                    accept;
   logic [REQ_ID_W-1:0]     act_id, head_id;
   logic [REQ_TYPE_W-1:0]   act_type, head_type;
   logic [ADDRESS_BITS-1:0] act_addr, head_addr;
   logic                    act_is_read, head_is_read, snoop_hit;

   assign busy   = reset;
   assign accept = start & ~busy;

   // queue entry layout: requester, type, address
   assign q_wr_data = {req_requester_id, req_request_type, req_address};
   assign {act_id, act_type, act_addr}    = active_ff;
   assign {head_id, head_type, head_addr} = q_head;

   assign act_is_read  = (act_type == RT_BUS_RD) || (act_type == RT_BUS_RDX);
   assign head_is_read = (head_type == RT_BUS_RD) || (head_type == RT_BUS_RDX);
   assign snoop_hit    = req_snoop_supplied & head_is_read;

   sbrs_request_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ENTRY_W     (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .wr_data   (q_wr_data),
      .status    (q_status),
      .fill      (q_fill),
      .head_data (q_head)
   );

   // configuration writes; out-of-range index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_latency_ff    <= RST_BUS_LATENCY;
         memory_latency_ff <= RST_MEMORY_LATENCY;
         block_size_ff     <= RST_BLOCK_SIZE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BUS_LATENCY:    bus_latency_ff    <= csr_write_data[LAT_W-1:0];
            CSR_MEMORY_LATENCY: memory_latency_ff <= csr_write_data[LAT_W-1:0];
            CSR_BLOCK_SIZE:     block_size_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // one pass of command processing
   always_comb begin
      q_ctrl          = '0;
      bus_busy_in     = bus_busy_ff;
      cycles_in       = cycles_ff;
      active_in       = active_ff;
      served_in       = served_ff;
      traffic_in      = traffic_ff;
      trans_in        = trans_ff;
      notify_valid_in = 1'b0;
      notify_req_in   = '0;
      notify_addr_in  = '0;
      notify_state_in = LS_SHARED;
      start_valid_in  = 1'b0;
      start_req_in    = '0;
      start_type_in   = '0;
      start_addr_in   = '0;
      dropped_in      = 1'b0;
      if (accept) begin
         unique case (req_action)
            ACT_PUSH: begin
               q_ctrl.push = 1'b1;
               dropped_in  = q_status.full;
            end
            ACT_TICK: begin
               if (bus_busy_ff) begin
                  if (cycles_ff <= LAT_W'(1)) begin
                     // completion; only reads and read-exclusives get a notice
                     bus_busy_in = 1'b0;
                     cycles_in   = '0;
                     if (act_is_read && (32'(act_id) < CACHE_COUNT)) begin
                        notify_valid_in = 1'b1;
                        notify_req_in   = act_id;
                        notify_addr_in  = act_addr;
                        if (act_type == RT_BUS_RDX) begin
                           notify_state_in = LS_MODIFIED;
                        end else if (served_ff) begin
                           notify_state_in = LS_SHARED;
                        end else begin
                           notify_state_in = LS_EXCLUSIVE;
                        end
                     end
                  end else begin
                     cycles_in = cycles_ff - 1'b1;
                  end
               end else if (!q_status.empty) begin
                  // start: pop head, broadcast for snoop, pick latency
                  q_ctrl.pop     = 1'b1;
                  active_in      = q_head;
                  served_in      = snoop_hit;
                  bus_busy_in    = 1'b1;
                  trans_in       = trans_ff + 1'b1;
                  traffic_in     = traffic_ff + CNT_W'(block_size_ff);
                  start_valid_in = 1'b1;
                  start_req_in   = head_id;
                  start_type_in  = head_type;
                  start_addr_in  = head_addr;
                  if (head_is_read) begin
                     cycles_in = snoop_hit ? bus_latency_ff : memory_latency_ff;
                  end else if ((head_type == RT_WRITEBACK) || (head_type == RT_FLUSH)) begin
                     cycles_in = memory_latency_ff;
                  end else begin
                     cycles_in = bus_latency_ff;
                  end
               end
            end
            ACT_WRITEBACK: begin
               trans_in   = trans_ff + 1'b1;
               traffic_in = traffic_ff + CNT_W'(block_size_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_busy_ff  <= 1'b0;
         cycles_ff    <= '0;
         active_ff    <= '0;
         served_ff    <= 1'b0;
         traffic_ff   <= '0;
         trans_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bus_busy_ff  <= bus_busy_in;
         cycles_ff    <= cycles_in;
         active_ff    <= active_in;
         served_ff    <= served_in;
         traffic_ff   <= traffic_in;
         trans_ff     <= trans_in;
         rsp_valid_ff <= accept;
      end
   end

   // result payload, meaningful while rsp_valid is high
   always_ff @(posedge clock) begin
      notify_valid_ff <= notify_valid_in;
      notify_req_ff   <= notify_req_in;
      notify_addr_ff  <= notify_addr_in;
      notify_state_ff <= notify_state_in;
      start_valid_ff  <= start_valid_in;
      start_req_ff    <= start_req_in;
      start_type_ff   <= start_type_in;
      start_addr_ff   <= start_addr_in;
      dropped_ff      <= dropped_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_notify_valid      = notify_valid_ff;
   assign rsp_notify_requester  = notify_req_ff;
   assign rsp_notify_address    = notify_addr_ff;
   assign rsp_notify_state      = notify_state_ff;
   assign rsp_start_valid       = start_valid_ff;
   assign rsp_start_requester   = start_req_ff;
   assign rsp_start_type        = start_type_ff;
   assign rsp_start_address     = start_addr_ff;
   // state registers already hold the post-item values during the strobe cycle
   assign rsp_queue_count       = q_fill;
   assign rsp_traffic_bytes     = traffic_ff;
   assign rsp_transaction_count = trans_ff;
   assign rsp_push_dropped      = dropped_ff;

   `SBRS_ASSERT(a_start_sets_busy, (rsp_valid_ff && start_valid_ff) |-> bus_busy_ff, "start left bus idle")
   `SBRS_ASSERT(a_notify_idles, (rsp_valid_ff && notify_valid_ff) |-> !bus_busy_ff, "notice with bus busy")
   `SBRS_ASSERT_NEVER(a_one_event, rsp_valid_ff && notify_valid_ff && start_valid_ff, "notice and start together")

endmodule
